### hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the balance cascade controller
// Number formats, configuration layout, sequencer states and the command
// bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcc_pkg;

   // fraction bits of the loop gains
   localparam int FracBits    = 8;
   localparam int ANGLE_FRAC  = 6;
   localparam int SPEED_FRAC  = 8;
   localparam int FILT_SHIFT  = 8;
   localparam int FILT_OLD    = 179;
   localparam int FILT_NEW    = 77;
   localparam int DRIVE_SPEED = 1000;

   // shared multiplier and accumulator widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 56;

   // configuration port
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 20;

   localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ANGLE     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KP       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_KD       = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP       = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI       = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_LIMIT    = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFFSET    = 3'd7;

   // drive modes
   localparam logic [2:0] MODE_STOP    = 3'd0;
   localparam logic [2:0] MODE_FORWARD = 3'd1;
   localparam logic [2:0] MODE_BACK    = 3'd2;
   localparam logic [2:0] MODE_LEFT    = 3'd3;
   localparam logic [2:0] MODE_RIGHT   = 3'd4;

   typedef struct packed {
      logic signed [15:0] zero_angle;
      logic [15:0]        angle_kp;
      logic [15:0]        angle_kd;
      logic [15:0]        speed_kp;
      logic [15:0]        speed_ki;
      logic [19:0]        distance_limit;
      logic [14:0]        motor_limit;
      logic [14:0]        turn_offset;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_P,
      ST_ANG_D,
      ST_ANG_SUM,
      ST_ANG_SAVE,
      ST_FLT_OLD,
      ST_FLT_NEW,
      ST_FLT_SUM,
      ST_FLT_SAVE,
      ST_DIST,
      ST_SPT_P,
      ST_SPT_I,
      ST_SPT_SUM,
      ST_SPT_SAVE,
      ST_MIX,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_ANG_P,
      MUL_ANG_D,
      MUL_FLT_OLD,
      MUL_FLT_NEW,
      MUL_SPT_P,
      MUL_SPT_I
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_SH
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        save_angle;
      logic        speed_prep;
      logic        save_filt;
      logic        upd_dist;
      logic        save_spt;
      logic        mix;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic speed_update;
   } sts_type;

   // saturate a wide signed value to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end else begin
         return x[31:0];
      end
   endfunction

endpackage

### hdl/bcc_regs.sv
// ----------------------------------------------------------------------------
// bcc_regs: configuration register file
// Holds the gains and limits; written one register per csr item.
// ----------------------------------------------------------------------------
module bcc_regs
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CFG_ZERO_ANGLE:     cfg_in.zero_angle     = csr_data[15:0];
            CFG_ANGLE_KP:       cfg_in.angle_kp       = csr_data[15:0];
            CFG_ANGLE_KD:       cfg_in.angle_kd       = csr_data[15:0];
            CFG_SPEED_KP:       cfg_in.speed_kp       = csr_data[15:0];
            CFG_SPEED_KI:       cfg_in.speed_ki       = csr_data[15:0];
            CFG_DISTANCE_LIMIT: cfg_in.distance_limit = csr_data[19:0];
            CFG_MOTOR_LIMIT:    cfg_in.motor_limit    = csr_data[14:0];
            CFG_TURN_OFFSET:    cfg_in.turn_offset    = csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_angle     <= 16'sd0;
         cfg_ff.angle_kp       <= 16'd25600;
         cfg_ff.angle_kd       <= 16'd79;
         cfg_ff.speed_kp       <= 16'd1536;
         cfg_ff.speed_ki       <= 16'd51;
         cfg_ff.distance_limit <= 20'd4000;
         cfg_ff.motor_limit    <= 15'd7200;
         cfg_ff.turn_offset    <= 15'd400;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/bcc_ctrl.sv
// ----------------------------------------------------------------------------
// bcc_ctrl: tick sequencer
// Steps the shared multiplier and accumulator through the angle term, the
// optional speed loop and the motor mix, and owns the item handshakes.
// ----------------------------------------------------------------------------
module bcc_ctrl
   import bcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_ANG_P;
         ST_ANG_P:    state_in = ST_ANG_D;
         ST_ANG_D:    state_in = ST_ANG_SUM;
         ST_ANG_SUM:  state_in = ST_ANG_SAVE;
         ST_ANG_SAVE: state_in = sts.speed_update ? ST_FLT_OLD : ST_MIX;
         ST_FLT_OLD:  state_in = ST_FLT_NEW;
         ST_FLT_NEW:  state_in = ST_FLT_SUM;
         ST_FLT_SUM:  state_in = ST_FLT_SAVE;
         ST_FLT_SAVE: state_in = ST_DIST;
         ST_DIST:     state_in = ST_SPT_P;
         ST_SPT_P:    state_in = ST_SPT_I;
         ST_SPT_I:    state_in = ST_SPT_SUM;
         ST_SPT_SUM:  state_in = ST_SPT_SAVE;
         ST_SPT_SAVE: state_in = ST_MIX;
         ST_MIX:      state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_ANG_P: cmd.mul_sel = MUL_ANG_P;
         ST_ANG_D: begin
            cmd.mul_sel = MUL_ANG_D;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_ANG_SUM: cmd.acc_op = ACC_ADD;
         ST_ANG_SAVE: begin
            cmd.save_angle = 1'b1;
            cmd.speed_prep = sts.speed_update;
         end
         ST_FLT_OLD: cmd.mul_sel = MUL_FLT_OLD;
         ST_FLT_NEW: begin
            cmd.mul_sel = MUL_FLT_NEW;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_FLT_SUM:  cmd.acc_op = ACC_ADD_SH;
         ST_FLT_SAVE: cmd.save_filt = 1'b1;
         ST_DIST:     cmd.upd_dist = 1'b1;
         ST_SPT_P:    cmd.mul_sel = MUL_SPT_P;
         ST_SPT_I: begin
            cmd.mul_sel = MUL_SPT_I;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_SPT_SUM:  cmd.acc_op = ACC_ADD;
         ST_SPT_SAVE: cmd.save_spt = 1'b1;
         ST_MIX:      cmd.mix = 1'b1;
         ST_OUT:      cmd.emit = out_free;
      endcase
   end

   // hold the result until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/bcc_dpath.sv
// ----------------------------------------------------------------------------
// bcc_dpath: controller datapath
// Held commands, encoder accumulators, speed loop state, one shared
// 34x18 multiplier with a registered product, an accumulator, and the
// motor mix with saturation and sign split.
// ----------------------------------------------------------------------------
module bcc_dpath
   import bcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic signed [15:0] roll_angle,
   input  logic signed [15:0] roll_rate,
   input  logic signed [15:0] left_count,
   input  logic signed [15:0] right_count,
   input  logic [2:0]         drive_mode,
   input  logic               speed_update,
   output sts_type            sts,
   output logic [14:0]        left_duty,
   output logic               left_reverse,
   output logic [14:0]        right_duty,
   output logic               right_reverse
);

   localparam int DIST_W  = 36;
   localparam int MOTOR_W = 35;

   // item operands
   logic signed [16:0]         diff_ff;
   logic signed [15:0]         rate_ff;
   logic                       upd_ff;

   // loop state
   logic signed [15:0]         speed_cmd_ff, speed_cmd_in;
   logic signed [15:0]         turn_cmd_ff, turn_cmd_in;
   logic signed [31:0]         left_accum_ff, left_accum_in;
   logic signed [31:0]         right_accum_ff, right_accum_in;
   logic signed [31:0]         filt_ff;
   logic signed [31:0]         dist_ff, dist_in;
   logic signed [31:0]         spt_ff;
   logic signed [MUL_A_W-1:0]  s_ff;

   // arithmetic unit
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, prod_ext;
   logic signed [31:0]         angle_ff;
   logic signed [MUL_A_W-1:0]  base_ff;

   // distance and motor clamps
   logic signed [DIST_W-1:0]   dist_sum, dist_lim;
   logic signed [MOTOR_W-1:0]  left_val, right_val, motor_lim;
   logic [15:0]                left_out, right_out;

   logic [14:0]                left_duty_ff, right_duty_ff;
   logic                       left_rev_ff, right_rev_ff;

   assign sts.speed_update = upd_ff;
   assign left_duty        = left_duty_ff;
   assign left_reverse     = left_rev_ff;
   assign right_duty       = right_duty_ff;
   assign right_reverse    = right_rev_ff;

   // clamp to +-lim and split into {reverse, magnitude}
   function automatic logic [15:0] motor_split(input logic signed [MOTOR_W-1:0] v,
                                               input logic signed [MOTOR_W-1:0] lim);
      logic signed [MOTOR_W-1:0] c;
      logic signed [MOTOR_W-1:0] mag;
      if (v > lim) begin
         c = lim;
      end else if (v < -lim) begin
         c = -lim;
      end else begin
         c = v;
      end
      mag = c[MOTOR_W-1] ? -c : c;
      return {c[MOTOR_W-1], mag[14:0]};
   endfunction

   // drive mode and encoder accumulation at capture
   always_comb begin
      speed_cmd_in = speed_cmd_ff;
      turn_cmd_in  = turn_cmd_ff;
      unique case (drive_mode)
         MODE_STOP: begin
            speed_cmd_in = '0;
            turn_cmd_in  = '0;
         end
         MODE_FORWARD: speed_cmd_in = 16'(DRIVE_SPEED);
         MODE_BACK:    speed_cmd_in = -16'(DRIVE_SPEED);
         MODE_LEFT:    turn_cmd_in  = -$signed({1'b0, cfg.turn_offset});
         MODE_RIGHT:   turn_cmd_in  = $signed({1'b0, cfg.turn_offset});
         default:      speed_cmd_in = '0;
      endcase
      left_accum_in  = sat32(ACC_W'(left_accum_ff) + ACC_W'(left_count));
      right_accum_in = sat32(ACC_W'(right_accum_ff) + ACC_W'(right_count));
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ANG_P: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = $signed({2'b00, cfg.angle_kp});
         end
         MUL_ANG_D: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = $signed({2'b00, cfg.angle_kd});
         end
         MUL_FLT_OLD: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = MUL_B_W'(FILT_OLD);
         end
         MUL_FLT_NEW: begin
            mul_a = s_ff;
            mul_b = MUL_B_W'(FILT_NEW);
         end
         MUL_SPT_P: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = $signed({2'b00, cfg.speed_kp});
         end
         MUL_SPT_I: begin
            mul_a = MUL_A_W'(dist_ff);
            mul_b = $signed({2'b00, cfg.speed_ki});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_LOAD:   acc_in = prod_ext;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         ACC_ADD_SH: acc_in = acc_ff + (prod_ext <<< FILT_SHIFT);
      endcase
   end

   // distance integral with symmetric clamp
   assign dist_lim = $signed(DIST_W'(cfg.distance_limit) << SPEED_FRAC);
   always_comb begin
      dist_sum = DIST_W'(dist_ff) + DIST_W'(filt_ff)
               + DIST_W'($signed({speed_cmd_ff, 8'h00}));
      if (dist_sum > dist_lim) begin
         dist_in = dist_lim[31:0];
      end else if (dist_sum < -dist_lim) begin
         dist_in = 32'(-dist_lim);
      end else begin
         dist_in = dist_sum[31:0];
      end
   end

   assign motor_lim = $signed(MOTOR_W'(cfg.motor_limit));
   assign left_val  = MOTOR_W'(base_ff) + MOTOR_W'(turn_cmd_ff);
   assign right_val = MOTOR_W'(base_ff) - MOTOR_W'(turn_cmd_ff);
   assign left_out  = motor_split(left_val, motor_lim);
   assign right_out = motor_split(right_val, motor_lim);

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cmd_ff   <= '0;
         turn_cmd_ff    <= '0;
         left_accum_ff  <= '0;
         right_accum_ff <= '0;
         filt_ff        <= '0;
         dist_ff        <= '0;
         spt_ff         <= '0;
         upd_ff         <= 1'b0;
      end else begin
         if (cmd.capture) begin
            speed_cmd_ff   <= speed_cmd_in;
            turn_cmd_ff    <= turn_cmd_in;
            left_accum_ff  <= left_accum_in;
            right_accum_ff <= right_accum_in;
            upd_ff         <= speed_update;
         end else if (cmd.speed_prep) begin
            left_accum_ff  <= '0;
            right_accum_ff <= '0;
         end
         if (cmd.save_filt) begin
            filt_ff <= sat32(acc_ff >>> FILT_SHIFT);
         end
         if (cmd.upd_dist) begin
            dist_ff <= dist_in;
         end
         if (cmd.save_spt) begin
            spt_ff <= sat32(acc_ff >>> (SPEED_FRAC + FracBits));
         end
      end
   end

   // operands and arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         diff_ff <= 17'(roll_angle) - 17'(cfg.zero_angle);
         rate_ff <= roll_rate;
      end
      if (cmd.speed_prep) begin
         s_ff <= -(MUL_A_W'(left_accum_ff) + MUL_A_W'(right_accum_ff));
      end
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (cmd.save_angle) begin
         angle_ff <= 32'(acc_ff >>> (ANGLE_FRAC + FracBits));
      end
      if (cmd.mix) begin
         base_ff <= MUL_A_W'(angle_ff) + MUL_A_W'(spt_ff);
      end
      if (cmd.emit) begin
         left_duty_ff  <= left_out[14:0];
         left_rev_ff   <= left_out[15];
         right_duty_ff <= right_out[14:0];
         right_rev_ff  <= right_out[15];
      end
   end

endmodule

### hdl/balance_cascade_controller.sv
// A tick runs the angle states and the motor mix, and with speed_update set
// also the filter, distance and speed PI states. A new item is taken only
// after the last item's result is registered; the single shared multiplier
// and accumulator step through every product of the tick in turn.
// Reset: synchronous, active high; clears all loop state and restores the
// default gains and limits.
// ----------------------------------------------------------------------------
// balance_cascade_controller: balancing robot cascade PD/PI controller
// Angle PD term plus a speed PI loop with low-pass filter and clamped
// distance integral, mixed with a turn offset into two motor drives.
// ----------------------------------------------------------------------------
module balance_cascade_controller
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: roll_angle[15:0], roll_rate[31:16], left_count[47:32],
   //            right_count[63:48], drive_mode[66:64], speed_update[67]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,
   // rsp_tdata: left_duty[14:0], left_reverse[15], right_duty[30:16],
   //            right_reverse[31]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   cfg_type     cfg;
   cmd_type     cmd;
   sts_type     sts;
   logic [14:0] left_duty, right_duty;
   logic        left_reverse, right_reverse;

   assign rsp_tdata = {right_reverse, right_duty, left_reverse, left_duty};

   bcc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bcc_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .roll_angle    (req_tdata[15:0]),
      .roll_rate     (req_tdata[31:16]),
      .left_count    (req_tdata[47:32]),
      .right_count   (req_tdata[63:48]),
      .drive_mode    (req_tdata[66:64]),
      .speed_update  (req_tdata[67]),
      .sts           (sts),
      .left_duty     (left_duty),
      .left_reverse  (left_reverse),
      .right_duty    (right_duty),
      .right_reverse (right_reverse)
   );

endmodule

### hdl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks of the balance cascade controller
// Watches the item handshakes and result encoding at the top-level ports.
// ----------------------------------------------------------------------------
module bcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // one tick in flight: input closes after an accepted item
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input ready right after an accepted item");

   // a zero drive never carries a reverse flag
   a_zero_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((rsp_tdata[14:0] == 15'd0) && rsp_tdata[15])
                  && !((rsp_tdata[30:16] == 15'd0) && rsp_tdata[31]))
      else $error("reverse flag set on zero drive");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind balance_cascade_controller bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/balance_cascade_controller_check.sv
// ----------------------------------------------------------------------------
// balance_cascade_controller_check: scoreboard for the cascade controller
// Watches the tick, drive and register channels, runs an independent model
// of the angle PD / speed PI cascade on every accepted tick and compares
// each motor drive item against the oldest prediction.
// ----------------------------------------------------------------------------
module balance_cascade_controller_check
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [71:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     GAIN_FRAC  = 8;
   localparam int     RATE_FRAC  = 6;
   localparam int     LP_FRAC    = 8;
   localparam longint LP_KEEP    = 179;
   localparam longint LP_TAKE    = 77;
   localparam int     CRUISE     = 1000;
   localparam longint WORD_MAX   = 64'sd2147483647;
   localparam longint WORD_MIN   = -64'sd2147483648;
   localparam int     REPORT_MAX = 10;

   localparam cfg_type GAINS_AT_RESET = '{
      zero_angle: 16'sd0, angle_kp: 16'd25600, angle_kd: 16'd79,
      speed_kp: 16'd1536, speed_ki: 16'd51, distance_limit: 20'd4000,
      motor_limit: 15'd7200, turn_offset: 15'd400};

   typedef struct packed {
      logic        right_reverse;
      logic [14:0] right_duty;
      logic        left_reverse;
      logic [14:0] left_duty;
   } motor_drive_type;

   cfg_type         gains;
   int              left_pulses;
   int              right_pulses;
   int              wheel_lp;
   int              travel;
   int              pi_drive;
   shortint         cruise_cmd;
   shortint         steer_cmd;
   motor_drive_type drive_expected[$];

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic int clip32(input longint x);
      return int'(clip(x, WORD_MIN, WORD_MAX));
   endfunction

   // advance the controller state by one tick and return the two drives
   function automatic motor_drive_type drive_for_tick(input logic [71:0] tick);
      longint roll;
      longint rate;
      longint angle;
      longint base;
      longint wheel_sum;
      longint lim;
      longint lv;
      longint rv;
      longint ml;
      motor_drive_type drive;
      roll = longint'($signed(tick[15:0]));
      rate = longint'($signed(tick[31:16]));
      case (tick[66:64])
         MODE_STOP: begin
            cruise_cmd = 0;
            steer_cmd = 0;
         end
         MODE_FORWARD: cruise_cmd = CRUISE;
         MODE_BACK: cruise_cmd = -CRUISE;
         MODE_LEFT: steer_cmd = -$signed({1'b0, gains.turn_offset});
         MODE_RIGHT: steer_cmd = $signed({1'b0, gains.turn_offset});
         default: cruise_cmd = 0;
      endcase
      left_pulses = clip32(longint'(left_pulses) + longint'($signed(tick[47:32])));
      right_pulses = clip32(longint'(right_pulses) + longint'($signed(tick[63:48])));
      angle = ((roll - longint'($signed(gains.zero_angle))) * longint'(gains.angle_kp)
               + rate * longint'(gains.angle_kd)) >>> (RATE_FRAC + GAIN_FRAC);
      if (tick[67]) begin
         wheel_sum = -(longint'(left_pulses) + longint'(right_pulses));
         left_pulses = 0;
         right_pulses = 0;
         wheel_lp = clip32((longint'(wheel_lp) * LP_KEEP + wheel_sum * LP_TAKE * 256)
                           >>> LP_FRAC);
         lim = longint'(gains.distance_limit) <<< LP_FRAC;
         travel = int'(clip(longint'(travel) + longint'(wheel_lp)
                            + longint'(cruise_cmd) * 256, -lim, lim));
         pi_drive = clip32((longint'(wheel_lp) * longint'(gains.speed_kp)
                            + longint'(travel) * longint'(gains.speed_ki))
                           >>> (LP_FRAC + GAIN_FRAC));
      end
      base = angle + longint'(pi_drive);
      ml = longint'(gains.motor_limit);
      lv = clip(base + longint'(steer_cmd), -ml, ml);
      rv = clip(base - longint'(steer_cmd), -ml, ml);
      drive.left_duty = 15'(lv < 0 ? -lv : lv);
      drive.left_reverse = lv < 0;
      drive.right_duty = 15'(rv < 0 ? -rv : rv);
      drive.right_reverse = rv < 0;
      return drive;
   endfunction

   task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
      case (idx)
         CFG_ZERO_ANGLE:     gains.zero_angle = $signed(value[15:0]);
         CFG_ANGLE_KP:       gains.angle_kp = value[15:0];
         CFG_ANGLE_KD:       gains.angle_kd = value[15:0];
         CFG_SPEED_KP:       gains.speed_kp = value[15:0];
         CFG_SPEED_KI:       gains.speed_ki = value[15:0];
         CFG_DISTANCE_LIMIT: gains.distance_limit = value;
         CFG_MOTOR_LIMIT:    gains.motor_limit = value[14:0];
         CFG_TURN_OFFSET:    gains.turn_offset = value[14:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      motor_drive_type want;
      motor_drive_type got;
      if (reset) begin
         gains = GAINS_AT_RESET;
         left_pulses = 0;
         right_pulses = 0;
         wheel_lp = 0;
         travel = 0;
         pi_drive = 0;
         cruise_cmd = 0;
         steer_cmd = 0;
         fail_count = 0;
         drive_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            drive_expected.push_back(drive_for_tick(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (drive_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("%0t: drive item with no tick pending: %h",
                           $realtime, rsp_tdata);
               end
            end else begin
               want = drive_expected.pop_front();
               if (got.left_duty != want.left_duty || got.left_reverse != want.left_reverse
                   || got.right_duty != want.right_duty
                   || got.right_reverse != want.right_reverse) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display({"%0t: drive mismatch: expected L %0d rev %0b R %0d rev %0b,",
                               " got L %0d rev %0b R %0d rev %0b"},
                              $realtime, want.left_duty, want.left_reverse,
                              want.right_duty, want.right_reverse, got.left_duty,
                              got.left_reverse, got.right_duty, got.right_reverse);
                  end
               end
            end
         end
      end
      waiting_count = drive_expected.size();
   end

endmodule

### bench/balance_cascade_controller_test.sv
// ----------------------------------------------------------------------------
// balance_cascade_controller_test: stimulus and verdict for the controller
// Runs directed ticks, one-sided encoder bursts and random ticks under several
// gain settings with random idling on both channels; the checker beside the
// block does the predicting and comparing.
// ----------------------------------------------------------------------------
module balance_cascade_controller_test
   import bcc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [71:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    waiting_count;
   logic                  steady = 1'b0;

   always #2 clock = ~clock;

   balance_cascade_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   balance_cascade_controller_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   // stall the drive channel now and then, never during a steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 20);
   end

   function automatic logic [71:0] pack_tick(input logic [15:0] roll, input logic [15:0] rate,
                                             input logic [15:0] lc, input logic [15:0] rc,
                                             input logic [2:0] mode, input logic upd);
      return {4'b0, upd, mode, rc, lc, rate, roll};
   endfunction

   function automatic logic [71:0] random_tick();
      logic [15:0] roll;
      logic [15:0] rate;
      logic [15:0] lc;
      logic [15:0] rc;
      logic [2:0]  mode;
      roll = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4000) - 2000) : 16'($urandom);
      rate = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4000) - 2000) : 16'($urandom);
      lc = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 600) - 300) : 16'($urandom);
      rc = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 600) - 300) : 16'($urandom);
      mode = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      return pack_tick(roll, rate, lc, rc, mode, $urandom_range(0, 3) == 0);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_tick(input logic [71:0] tick);
      while (!steady && $urandom_range(0, 99) < 20) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = tick;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (waiting_count != 0) @(negedge clock);
   endtask

   task automatic load_gains(input logic [15:0] za, input logic [15:0] akp,
                             input logic [15:0] akd, input logic [15:0] skp,
                             input logic [15:0] ski, input logic [19:0] dlim,
                             input logic [14:0] mlim, input logic [14:0] turn);
      drain();
      write_reg(CFG_ZERO_ANGLE, 20'(za));
      write_reg(CFG_ANGLE_KP, 20'(akp));
      write_reg(CFG_ANGLE_KD, 20'(akd));
      write_reg(CFG_SPEED_KP, 20'(skp));
      write_reg(CFG_SPEED_KI, 20'(ski));
      write_reg(CFG_DISTANCE_LIMIT, dlim);
      write_reg(CFG_MOTOR_LIMIT, 20'(mlim));
      write_reg(CFG_TURN_OFFSET, 20'(turn));
   endtask

   task automatic random_ticks(input int count);
      repeat (count) send_tick(random_tick());
   endtask

   task automatic burst(input int count, input logic [15:0] pulses, input logic [2:0] mode);
      repeat (count) begin
         send_tick(pack_tick(16'($urandom_range(0, 400) - 200), 16'($urandom), pulses,
                             pulses, mode, 1'b0));
      end
   endtask

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed ticks under the reset gains
      send_tick(pack_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, MODE_STOP, 1'b0));
      send_tick(pack_tick(16'sd32767, 16'sd32767, 16'sd0, 16'sd0, MODE_STOP, 1'b0));
      send_tick(pack_tick(-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, MODE_STOP, 1'b0));
      send_tick(pack_tick(16'sd100, -16'sd50, 16'sd120, 16'sd130, MODE_FORWARD, 1'b1));
      send_tick(pack_tick(16'sd40, 16'sd10, -16'sd32768, -16'sd32768, MODE_BACK, 1'b1));
      send_tick(pack_tick(-16'sd60, 16'sd5, 16'sd32767, 16'sd32767, MODE_LEFT, 1'b0));
      send_tick(pack_tick(16'sd0, 16'sd0, 16'sd32767, -16'sd32768, MODE_RIGHT, 1'b1));
      send_tick(pack_tick(16'sd20, -16'sd20, 16'sd15, 16'sd10, 3'd5, 1'b1));
      send_tick(pack_tick(16'sd300, 16'sd0, -16'sd7, 16'sd3, 3'd6, 1'b0));
      send_tick(pack_tick(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 3'd7, 1'b1));
      send_tick(pack_tick(16'sd64, 16'sd64, 16'sd200, 16'sd200, MODE_FORWARD, 1'b0));
      send_tick(pack_tick(16'sd64, 16'sd64, 16'sd200, 16'sd200, MODE_LEFT, 1'b1));
      send_tick(pack_tick(-16'sd640, 16'sd100, -16'sd50, -16'sd50, MODE_BACK, 1'b1));
      send_tick(pack_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, MODE_STOP, 1'b1));
      send_tick(pack_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, MODE_STOP, 1'b1));

      // largest gains and limits; then long one-sided encoder bursts
      load_gains(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 15'h7FFF,
                 15'h7FFF);
      random_ticks(100);
      steady = 1'b1;
      burst(40, 16'sd32767, MODE_FORWARD);
      repeat (5) send_tick(pack_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, MODE_RIGHT, 1'b1));
      burst(40, -16'sd32768, MODE_BACK);
      repeat (5) send_tick(pack_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, MODE_LEFT, 1'b1));
      steady = 1'b0;

      // zero gains and limits
      load_gains(16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 20'h0, 15'h0, 15'h0);
      random_ticks(60);

      // moderate random settings, one of them without any idling
      for (int phase = 0; phase < 3; phase++) begin
         load_gains(16'($urandom_range(0, 1000) - 500), 16'($urandom_range(0, 40000)),
                    16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                    16'($urandom_range(0, 400)), 20'($urandom_range(0, 8000)),
                    15'($urandom), 15'($urandom_range(0, 4000)));
         steady = (phase == 1);
         random_ticks(95);
      end
      steady = 1'b0;

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && waiting_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
